[sv/canonical_state_space_filter_step_defines.svh]
// Assertion macros for the state space filter step.
`ifndef CANONICAL_STATE_SPACE_FILTER_STEP_DEFINES_SVH
`define CANONICAL_STATE_SPACE_FILTER_STEP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clock, off during reset
`define CSS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("css: implication check failed");
// next-cycle implication
`define CSS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("css: next-cycle check failed");
`else
`define CSS_ASSERT_IMP(name, ante, cons)
`define CSS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[sv/css_pkg.sv]
package css_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int ORDER_W     = 2;
   localparam int STATE_W     = 48;
   localparam int ACC_W       = 58;
   localparam int SUM_W       = 59;
   localparam int OPND_W      = 33;
   localparam int PROD_W      = 66;
   localparam int SPLIT_W     = 16;
   localparam int LO_W        = 34;
   localparam int SHIFT_NARROW = 8;
   localparam int SHIFT_WIDE  = 16;
   localparam int ROUND_SHIFT = 8;
   localparam int ROUND_HALF  = 128;
   localparam int PC_W        = 4;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FB0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT0  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN  = 3'd7;

   localparam logic [PC_W-1:0] PC_STEP    = 4'd0;
   localparam logic [PC_W-1:0] PC_YV_LOOP = 4'd1;
   localparam logic [PC_W-1:0] PC_X_START = 4'd5;
   localparam logic [PC_W-1:0] PC_X_LOOP  = 4'd6;
   localparam logic [PC_W-1:0] PC_X_LAST  = 4'd7;
   localparam logic [PC_W-1:0] PC_V_WAIT  = 4'd8;
   localparam logic [PC_W-1:0] PC_V_LATCH = 4'd9;
   localparam logic [PC_W-1:0] PC_V_LO    = 4'd10;
   localparam logic [PC_W-1:0] PC_V_HI    = 4'd11;
   localparam logic [PC_W-1:0] PC_EMIT    = 4'd12;
   localparam logic [PC_W-1:0] PC_CLEAR   = 4'd13;

   typedef enum logic [2:0] {
      A_U   = 3'd0,
      A_XLO = 3'd1,
      A_XHI = 3'd2,
      A_VLO = 3'd3,
      A_VHI = 3'd4
   } opa_type;

   typedef enum logic [1:0] {
      B_GAIN = 2'd0,
      B_OUT  = 2'd1,
      B_FB   = 2'd2,
      B_DT   = 2'd3
   } opb_type;

   typedef enum logic [1:0] {
      P_NONE = 2'd0,
      P_LO   = 2'd1,
      P_HI   = 2'd2,
      P_FULL = 2'd3
   } part_type;

   typedef enum logic [1:0] {
      D_Y      = 2'd0,
      D_V      = 2'd1,
      D_S_PREV = 2'd2,
      D_S_TOP  = 2'd3
   } dest_type;

   typedef enum logic [1:0] {
      I_HOLD = 2'd0,
      I_ZERO = 2'd1,
      I_ONE  = 2'd2,
      I_INC  = 2'd3
   } idx_type;

   typedef enum logic [1:0] {
      Q_NEXT = 2'd0,
      Q_LOOP = 2'd1,
      Q_ONE  = 2'd2,
      Q_DONE = 2'd3
   } seq_type;

   typedef struct packed {
      opa_type          opa;
      opb_type          opb;
      part_type         part;
      dest_type         dest;
      logic             shr16;
      logic             init;
      logic             vlatch;
      logic             emit;
      logic             clr;
      idx_type          idx;
      seq_type          seq;
      logic [PC_W-1:0]  target;
   } ctl_type;

   typedef struct packed {
      part_type part;
      dest_type dest;
      logic     shr16;
   } tag_type;

   localparam ctl_type CTL_NOP = '{
      opa: A_U, opb: B_GAIN, part: P_NONE, dest: D_Y, shr16: 1'b0, init: 1'b0,
      vlatch: 1'b0, emit: 1'b0, clr: 1'b0, idx: I_HOLD, seq: Q_NEXT, target: '0
   };

   localparam tag_type TAG_NOP = '{part: P_NONE, dest: D_Y, shr16: 1'b0};

   // microcode: gain term, output and feedback dot products, lower-state increments,
   // then the top-state increment from the saturated drive, the result emit, and the clear step
   function automatic ctl_type css_rom(input logic [PC_W-1:0] addr);
      ctl_type w;
      w = CTL_NOP;
      unique case (addr)
         PC_STEP: begin
            w.opa = A_U;   w.opb = B_GAIN; w.part = P_FULL; w.dest = D_Y;
            w.init = 1'b1; w.idx = I_ZERO;
         end
         PC_YV_LOOP: begin
            w.opa = A_XLO; w.opb = B_OUT;  w.part = P_LO;
         end
         4'd2: begin
            w.opa = A_XHI; w.opb = B_OUT;  w.part = P_HI;   w.dest = D_Y;
         end
         4'd3: begin
            w.opa = A_XLO; w.opb = B_FB;   w.part = P_LO;
         end
         4'd4: begin
            w.opa = A_XHI; w.opb = B_FB;   w.part = P_HI;   w.dest = D_V;
            w.idx = I_INC; w.seq = Q_LOOP; w.target = PC_YV_LOOP;
         end
         PC_X_START: begin
            w.idx = I_ONE; w.seq = Q_ONE;  w.target = PC_V_WAIT;
         end
         PC_X_LOOP: begin
            w.opa = A_XLO; w.opb = B_DT;   w.part = P_LO;
         end
         PC_X_LAST: begin
            w.opa = A_XHI; w.opb = B_DT;   w.part = P_HI;   w.dest = D_S_PREV;
            w.shr16 = 1'b1; w.idx = I_INC; w.seq = Q_LOOP; w.target = PC_X_LOOP;
         end
         PC_V_WAIT: begin
            w = CTL_NOP;
         end
         PC_V_LATCH: begin
            w.vlatch = 1'b1;
         end
         PC_V_LO: begin
            w.opa = A_VLO; w.opb = B_DT;   w.part = P_LO;
         end
         PC_V_HI: begin
            w.opa = A_VHI; w.opb = B_DT;   w.part = P_HI;   w.dest = D_S_TOP;
         end
         PC_EMIT: begin
            w.emit = 1'b1; w.seq = Q_DONE;
         end
         PC_CLEAR: begin
            w.clr = 1'b1;  w.seq = Q_DONE;
         end
         default: begin
            w.seq = Q_DONE;
         end
      endcase
      return w;
   endfunction

   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
      if (x[SUM_W-1:STATE_W-1] == '0 || x[SUM_W-1:STATE_W-1] == '1) begin
         return x[STATE_W-1:0];
      end
      return x[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
      if (x[SUM_W-1:SAMPLE_W-1] == '0 || x[SUM_W-1:SAMPLE_W-1] == '1) begin
         return x[SAMPLE_W-1:0];
      end
      return x[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
   endfunction

endpackage

[sv/canonical_state_space_filter_step.sv]
// Channel  Dir  Handshake              Payload
// req      in   req_valid/req_stall    req_operation, req_sample_in, req_time_step
// rsp      out  rsp_valid/rsp_stall    rsp_sample_out
// csr      in   csr_write_en           csr_index, csr_data
// Advance transfer: a new request is accepted only once the previous transfer is done;
// one shared 33x33 multiplier takes one partial product per cycle, two per 48x32 product.
// Clear transfer: zeroes the states, no result.
// Reset (synchronous) zeroes the states and loads order 1 and zero coefficients.
// A result held by rsp_stall stalls only the last microcode step (the emit) of the next advance transfer.
`include "canonical_state_space_filter_step_defines.svh"

module canonical_state_space_filter_step
   import css_pkg::*;
#(
   parameter int MAX_ORDER = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic        [SAMPLE_W-1:0] req_time_step,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_write_en,
   input  logic       [CSR_IDX_W-1:0] csr_index,
   input  logic        [SAMPLE_W-1:0] csr_data
);

   localparam int CNT_W  = $clog2(MAX_ORDER + 1);
   localparam int SIDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   logic        [ORDER_W-1:0]  order_ff;
   logic signed [SAMPLE_W-1:0] fb_ff [MAX_ORDER];
   logic signed [SAMPLE_W-1:0] oc_ff [MAX_ORDER];
   logic signed [SAMPLE_W-1:0] gain_ff;
   logic        [ORDER_W-1:0]  order_clip;
   logic        [CNT_W-1:0]    n_eff, last_idx;
   logic                       order_one;

   logic                       busy, start, hold, out_full, emit_fire;
   ctl_type                    ctl;
   logic        [CNT_W-1:0]    idx;
   logic        [SIDX_W-1:0]   sidx;

   logic signed [SAMPLE_W-1:0] u_ff;
   logic        [SAMPLE_W-1:0] dt_ff;
   logic signed [STATE_W-1:0]  st_ff [MAX_ORDER];
   logic signed [SUM_W-1:0]    st_sum [MAX_ORDER];
   logic signed [STATE_W-1:0]  x_cur, v_ff;

   logic signed [OPND_W-1:0]   opa_val, opb_val;
   logic signed [PROD_W-1:0]   prod_in, prod_ff, hi_sum;
   tag_type                    tag1_ff;
   logic        [CNT_W-1:0]    wb_in, wb1_ff, wb2_ff;
   logic signed [LO_W-1:0]     lo_ff;
   logic signed [ACC_W-1:0]    term_in, term_ff, acc_y_ff, acc_v_ff;
   logic                       add_in, add_ff, wb_state;
   dest_type                   dest2_ff;

   logic signed [SUM_W-1:0]    rnd_sum, rnd_shift;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_W'(1);
         gain_ff  <= '0;
         for (int j = 0; j < MAX_ORDER; j++) begin
            fb_ff[j] <= '0;
            oc_ff[j] <= '0;
         end
      end else if (csr_write_en) begin
         if (csr_index == REG_ORDER) order_ff <= csr_data[ORDER_W-1:0];
         if (csr_index == REG_GAIN)  gain_ff  <= $signed(csr_data);
         for (int j = 0; j < MAX_ORDER; j++) begin
            if (csr_index == REG_FB0 + CSR_IDX_W'(j))  fb_ff[j] <= $signed(csr_data);
            if (csr_index == REG_OUT0 + CSR_IDX_W'(j)) oc_ff[j] <= $signed(csr_data);
         end
      end
   end

   always_comb begin
      if (order_ff == '0) begin
         order_clip = ORDER_W'(1);
      end else if (order_ff > ORDER_W'(MAX_ORDER)) begin
         order_clip = ORDER_W'(MAX_ORDER);
      end else begin
         order_clip = order_ff;
      end
   end

   assign n_eff     = CNT_W'(order_clip);
   assign last_idx  = n_eff - 1'b1;
   assign order_one = (order_clip == ORDER_W'(1));

   // sequencer
   assign start     = req_valid && !busy;
   assign req_stall = busy;
   assign out_full  = rsp_valid_ff && rsp_stall;
   assign hold      = ctl.emit && out_full;
   assign emit_fire = ctl.emit && !out_full;

   css_seq #(
      .MAX_ORDER(MAX_ORDER)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_clear(req_operation),
      .last_idx   (last_idx),
      .order_one  (order_one),
      .hold       (hold),
      .busy       (busy),
      .ctl        (ctl),
      .idx        (idx)
   );

   always_ff @(posedge clock) begin
      if (start) begin
         u_ff  <= req_sample_in;
         dt_ff <= req_time_step;
      end
   end

   // operand select
   assign sidx  = idx[SIDX_W-1:0];
   assign x_cur = st_ff[sidx];

   always_comb begin
      unique case (ctl.opa)
         A_U:     opa_val = OPND_W'(u_ff);
         A_XLO:   opa_val = $signed({{(OPND_W-SPLIT_W){1'b0}}, x_cur[SPLIT_W-1:0]});
         A_XHI:   opa_val = OPND_W'($signed(x_cur[STATE_W-1:SPLIT_W]));
         A_VLO:   opa_val = $signed({{(OPND_W-SPLIT_W){1'b0}}, v_ff[SPLIT_W-1:0]});
         A_VHI:   opa_val = OPND_W'($signed(v_ff[STATE_W-1:SPLIT_W]));
         default: opa_val = '0;
      endcase
   end

   always_comb begin
      unique case (ctl.opb)
         B_GAIN: opb_val = OPND_W'(gain_ff);
         B_OUT:  opb_val = OPND_W'(oc_ff[sidx]);
         B_FB:   opb_val = OPND_W'(fb_ff[sidx]);
         B_DT:   opb_val = $signed({1'b0, dt_ff});
      endcase
   end

   assign prod_in = opa_val * opb_val;
   assign wb_in   = (ctl.dest == D_S_TOP) ? last_idx : idx - 1'b1;

   // multiply stage
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      wb1_ff  <= wb_in;
      if (reset) begin
         tag1_ff <= TAG_NOP;
      end else begin
         tag1_ff <= '{part: ctl.part, dest: ctl.dest, shr16: ctl.shr16};
      end
   end

   // combine stage: floor((hi*m + floor(lo*m / 2^16)) / 2^s)
   assign hi_sum = prod_ff + PROD_W'(lo_ff);
   assign add_in = (tag1_ff.part == P_HI) || (tag1_ff.part == P_FULL);

   always_comb begin
      unique case (tag1_ff.part)
         P_FULL:  term_in = ACC_W'(prod_ff >>> SHIFT_NARROW);
         P_HI:    term_in = tag1_ff.shr16 ? ACC_W'(hi_sum >>> SHIFT_WIDE)
                                          : ACC_W'(hi_sum >>> SHIFT_NARROW);
         default: term_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tag1_ff.part == P_LO) lo_ff <= $signed(prod_ff[SPLIT_W+LO_W-1:SPLIT_W]);
      term_ff  <= term_in;
      dest2_ff <= tag1_ff.dest;
      wb2_ff   <= wb1_ff;
      if (reset) begin
         add_ff <= 1'b0;
      end else begin
         add_ff <= add_in;
      end
   end

   // accumulate stage
   assign wb_state = add_ff && (dest2_ff == D_S_PREV || dest2_ff == D_S_TOP);

   always_ff @(posedge clock) begin
      if (ctl.init) begin
         acc_y_ff <= '0;
         acc_v_ff <= ACC_W'(u_ff) <<< ROUND_SHIFT;
      end else if (add_ff) begin
         if (dest2_ff == D_Y) acc_y_ff <= acc_y_ff + term_ff;
         if (dest2_ff == D_V) acc_v_ff <= acc_v_ff + term_ff;
      end
      if (ctl.vlatch) v_ff <= sat48(SUM_W'(acc_v_ff));
   end

   always_comb begin
      for (int j = 0; j < MAX_ORDER; j++) begin
         st_sum[j] = SUM_W'(st_ff[j]) + SUM_W'(term_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_ORDER; j++) begin
         if (reset || ctl.clr) begin
            st_ff[j] <= '0;
         end else if (wb_state && wb2_ff == CNT_W'(j)) begin
            st_ff[j] <= sat48(st_sum[j]);
         end
      end
   end

   // result register
   assign rnd_sum      = SUM_W'(acc_y_ff) + SUM_W'(ROUND_HALF);
   assign rnd_shift    = rnd_sum >>> ROUND_SHIFT;
   assign rsp_valid_in = emit_fire || out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit_fire) rsp_data_ff <= sat32(rnd_shift);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   `CSS_ASSERT_NEXT(a_start_busy, start, busy)
   `CSS_ASSERT_IMP(a_clear_no_wb, wb_state, !ctl.clr)
   `CSS_ASSERT_IMP(a_init_drained, ctl.init, tag1_ff.part == P_NONE && !add_ff)
   `CSS_ASSERT_NEXT(a_hold_keeps_emit, hold, busy && ctl.emit)

endmodule

[sv/css_seq.sv]
module css_seq
   import css_pkg::*;
#(
   parameter int MAX_ORDER = 3,
   localparam int CNT_W = $clog2(MAX_ORDER + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             start_clear,
   input  logic [CNT_W-1:0] last_idx,
   input  logic             order_one,
   input  logic             hold,
   output logic             busy,
   output ctl_type          ctl,
   output logic [CNT_W-1:0] idx
);

   logic             busy_ff, busy_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             take_jump;
   ctl_type          rom_word;

   assign rom_word = css_rom(pc_ff);
   assign ctl      = busy_ff ? rom_word : CTL_NOP;
   assign busy     = busy_ff;
   assign idx      = idx_ff;

   always_comb begin
      busy_in   = busy_ff;
      pc_in     = pc_ff;
      idx_in    = idx_ff;
      take_jump = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = start_clear ? PC_CLEAR : PC_STEP;
         end
      end else if (!hold) begin
         unique case (rom_word.seq)
            Q_NEXT: take_jump = 1'b0;
            Q_LOOP: take_jump = (idx_ff != last_idx);
            Q_ONE:  take_jump = order_one;
            Q_DONE: busy_in = 1'b0;
         endcase
         pc_in = take_jump ? rom_word.target : pc_ff + 1'b1;
         unique case (rom_word.idx)
            I_HOLD: idx_in = idx_ff;
            I_ZERO: idx_in = '0;
            I_ONE:  idx_in = CNT_W'(1);
            I_INC:  idx_in = idx_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_STEP;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

[tb/canonical_state_space_filter_step_tb.sv]
`timescale 1ns / 1ps

module canonical_state_space_filter_step_tb;
   import css_pkg::*;

   typedef logic signed [127:0] wide_t;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;
   localparam int ORDER_MAX     = 3;
   localparam int Q16_TO_Q24    = 8;
   localparam int PROD_TO_Q24   = 24;
   localparam int PROD_TO_Q32   = 32;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 128;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRESSURE_PHASE = 4;
   localparam int REPORT_CAP    = 40;

   // Tracks filter states and coefficients, holds the sample_out values still owed.
   class state_space_tracker;
      logic [ORDER_W-1:0]         order_reg;
      logic signed [SAMPLE_W-1:0] fb_coef[ORDER_MAX];
      logic signed [SAMPLE_W-1:0] out_coef[ORDER_MAX];
      logic signed [SAMPLE_W-1:0] gain;
      logic signed [STATE_W-1:0]  x[ORDER_MAX];
      logic signed [SAMPLE_W-1:0] pending_outputs[$];
      int mismatches, advances, clears, rail_outputs;

      function new();
         order_reg = 1;
         gain = 0;
         for (int i = 0; i < ORDER_MAX; i++) begin
            fb_coef[i] = 0;
            out_coef[i] = 0;
            x[i] = 0;
         end
         mismatches = 0;
         advances = 0;
         clears = 0;
         rail_outputs = 0;
      endfunction

      // exact product, floored by an arithmetic shift
      function wide_t scaled_product(wide_t a, wide_t b, int shift);
         wide_t p;
         p = a * b;
         return p >>> shift;
      endfunction

      function wide_t clamp(wide_t a, int bits);
         wide_t top;
         top = 1;
         top = (top <<< (bits - 1)) - 1;
         if (a > top) return top;
         if (a < -top - 1) return -top - 1;
         return a;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
         if (idx == REG_ORDER) begin
            order_reg = data[ORDER_W-1:0];
         end else if (idx < REG_OUT0) begin
            fb_coef[idx - REG_FB0] = data;
         end else if (idx < REG_GAIN) begin
            out_coef[idx - REG_OUT0] = data;
         end else begin
            gain = data;
         end
      endfunction

      function void take_step(logic op, logic signed [SAMPLE_W-1:0] u,
                              logic [SAMPLE_W-1:0] dt);
         wide_t y, v, r;
         wide_t nx[ORDER_MAX];
         int n;
         if (op == OP_CLEAR) begin
            clears++;
            for (int i = 0; i < ORDER_MAX; i++) x[i] = 0;
            return;
         end
         advances++;
         n = (order_reg == 0) ? 1 : int'(order_reg);
         y = scaled_product(gain, u, Q16_TO_Q24);
         v = u;
         v = v <<< Q16_TO_Q24;
         for (int i = 0; i < n; i++) begin
            y += scaled_product(x[i], out_coef[i], PROD_TO_Q24);
            v += scaled_product(x[i], fb_coef[i], PROD_TO_Q24);
         end
         r = clamp((y + ROUND_HALF) >>> ROUND_SHIFT, SAMPLE_W);
         if (r[SAMPLE_W-1:0] == 32'h7FFF_FFFF || r[SAMPLE_W-1:0] == 32'h8000_0000)
            rail_outputs++;
         pending_outputs.push_back(r[SAMPLE_W-1:0]);
         v = clamp(v, STATE_W);
         for (int i = 0; i < n - 1; i++)
            nx[i] = clamp(x[i] + scaled_product(x[i + 1], dt, PROD_TO_Q32), STATE_W);
         nx[n - 1] = clamp(x[n - 1] + scaled_product(v, dt, PROD_TO_Q24), STATE_W);
         for (int i = 0; i < n; i++) x[i] = nx[i][STATE_W-1:0];
      endfunction

      function void compare_output(logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (pending_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t ERROR: sample_out expected none, actual %0d", $time, got);
            return;
         end
         want = pending_outputs.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t ERROR: sample_out expected %0d, actual %0d", $time, want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = OP_ADVANCE;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic [SAMPLE_W-1:0] req_time_step = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0] csr_data = '0;

   state_space_tracker tracker = new();
   logic [SAMPLE_W-1:0] coef_set[7];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_left = 0;
   int cycle_count = 0;
   int settings_count = 0;

   canonical_state_space_filter_step #(.MAX_ORDER(ORDER_MAX)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_sample_in(req_sample_in),
      .req_time_step(req_time_step),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.compare_output(rsp_sample_out);
   end

   function automatic bit chance(int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // receiver: long hold-off first if one is pending, else random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= chance(recv_idle_pct);
         end
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int sel;
      sel = $urandom_range(3, 0);
      case (sel)
         0: return $urandom_range(32'h0007_FFFF, 0) - 32'h0004_0000;
         1: begin
            case ($urandom_range(3, 0))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_step();
      int sel;
      sel = $urandom_range(3, 0);
      case (sel)
         0: return $urandom_range(32'h0100_0000, 0);
         1: return $urandom_range(32'h1000_0000, 0);
         2: return chance(50) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_coef();
      int sel;
      sel = $urandom_range(99, 0);
      if (sel < 40) return $urandom_range(32'h0003_FFFF, 0) - 32'h0002_0000;
      if (sel < 70) return $urandom;
      if (sel < 85) return 32'h0000_0000;
      return chance(50) ? 32'h7FFF_FFFF : 32'h8000_0000;
   endfunction

   task automatic send_item(logic op, logic signed [SAMPLE_W-1:0] u, logic [SAMPLE_W-1:0] dt);
      @(negedge clock);
      while (chance(send_idle_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_sample_in <= u;
      req_time_step <= dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_step(op, u, dt);
   endtask

   task automatic send_random_item();
      logic op;
      op = chance(6) ? OP_CLEAR : OP_ADVANCE;
      send_item(op, pick_sample(), pick_step());
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes the order register, then coef_set into the coefficient registers
   task automatic program_filter(logic [SAMPLE_W-1:0] order_data);
      logic [SAMPLE_W-1:0] data;
      for (int k = REG_ORDER; k <= REG_GAIN; k++) begin
         data = (k == REG_ORDER) ? order_data : coef_set[k - REG_FB0];
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_data <= data;
         @(posedge clock);
         tracker.write_reg(CSR_IDX_W'(k), data);
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings_count++;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: order 1, zero coefficients
      send_item(OP_ADVANCE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_ADVANCE, 32'h0001_0000, 32'h8000_0000);
      settle();

      coef_set = '{32'hFFFF_0000, 32'hFFFF_8000, 32'h8000_0000,
                   32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      program_filter(32'h0000_0003);
      send_item(OP_CLEAR, 32'h0, 32'h0);
      repeat (3) send_item(OP_ADVANCE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      repeat (3) send_item(OP_ADVANCE, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(OP_ADVANCE, 32'h0, 32'h0);
      send_item(OP_ADVANCE, 32'h1, 32'h1);
      send_item(OP_ADVANCE, 32'hFFFF_FFFF, 32'h8000_0000);
      send_item(OP_CLEAR, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_ADVANCE, 32'h1234_5678, 32'h0100_0000);
      settle();
      // order zero behaves as order one
      program_filter(32'hFFFF_FFFC);
      repeat (2) send_item(OP_ADVANCE, 32'h0002_0000, 32'h4000_0000);
      settle();
      // top state left untouched at order two
      program_filter(32'h0000_0002);
      repeat (2) send_item(OP_ADVANCE, 32'hFFFF_0000, 32'h2000_0000);
      settle();
      program_filter(32'h0000_0003);
      repeat (2) send_item(OP_ADVANCE, 32'hFFFE_0000, 32'h2000_0000);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         for (int k = 0; k < 7; k++) begin
            if (p == 0) coef_set[k] = 32'h8000_0000;
            else if (p == 1) coef_set[k] = 32'h7FFF_FFFF;
            else coef_set[k] = pick_coef();
         end
         program_filter(p == 0 ? 32'h0000_0003 : p == 1 ? 32'hFFFF_FFFD : $urandom);
         case (idle_mode_e'(p % 4))
            IDLE_NONE: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct = 73;
               recv_idle_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct = 0;
               recv_idle_pct = 73;
            end
            default: begin
               send_idle_pct = 9;
               recv_idle_pct = 9;
            end
         endcase
         if (p == PRESSURE_PHASE) rsp_hold_left = HOLD_CYCLES;
         repeat (PHASE_ITEMS) send_random_item();
      end
      settle();

      $display("Covered %0d advance and %0d clear transfers over %0d register settings,",
               tracker.advances, tracker.clears, settings_count);
      $display("with %0d outputs at a saturation rail and %0d mismatches.",
               tracker.rail_outputs, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/css_pkg.sv
sv/css_seq.sv
sv/canonical_state_space_filter_step.sv
tb/canonical_state_space_filter_step_tb.sv
